// ===== rtl/dpbt_pkg.sv =====
package dpbt_pkg;

    // Default width of the word counter.
    localparam int DEF_WORD_INDEX_BITS = 32;

    localparam int DATA_W       = 64;
    localparam int COUNT_W      = 32;
    localparam int PAGE_LOG2_W  = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int BYTE_SHIFT   = 3;

    localparam logic [PAGE_LOG2_W-1:0] MAX_PAGE_LOG2   = 5'd20;
    localparam logic [PAGE_LOG2_W-1:0] PAGE_LOG2_RESET = 5'd9;

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE      = 2'd0,
        CFG_PAGE_LOG2 = 2'd1,
        CFG_BASE_ADDR = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                   mode;
        logic [PAGE_LOG2_W-1:0] page_log2;
        logic [DATA_W-1:0]      base_address;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] word_a;
        logic [DATA_W-1:0] word_b;
        logic              page_marked;
        logic              last;
    } t_item;

endpackage

// ===== rtl/dpbt_core.sv =====
module dpbt_core
    import dpbt_pkg::*;
#(
    parameter int WORD_INDEX_BITS = DEF_WORD_INDEX_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COUNT_W-1:0] o_page_index,
    output logic               o_dirty_flag,
    output logic [COUNT_W-1:0] o_dirty_total,
    output logic               o_error_found,
    output logic [DATA_W-1:0]  o_error_address,
    output logic               o_end_of_region
);

    localparam logic [5:0] IDX_BITS = 6'(WORD_INDEX_BITS);

    logic [WORD_INDEX_BITS-1:0] r_word_counter;
    logic                       r_cur_dirty;
    logic [COUNT_W-1:0]         r_dirty_count;
    logic                       r_err;
    logic [DATA_W-1:0]          r_err_addr;

    logic                       r_out_valid;
    logic [COUNT_W-1:0]         r_page_index;
    logic                       r_out_dirty;
    logic [COUNT_W-1:0]         r_out_total;
    logic                       r_out_err;
    logic [DATA_W-1:0]          r_out_err_addr;
    logic                       r_out_end;

    logic                       n_cur_dirty;
    logic [COUNT_W-1:0]         n_dirty_count;
    logic                       n_err;
    logic [DATA_W-1:0]          n_err_addr;
    logic [WORD_INDEX_BITS-1:0] in_page_mask;
    logic                       page_end;
    logic                       emit;
    logic                       differs;
    logic [DATA_W-1:0]          idx_ext;
    logic [DATA_W-1:0]          idx_shifted;

    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        in_page_mask = ~({WORD_INDEX_BITS{1'b1}} << i_cfg.page_log2);
        // A page longer than the counter never reaches its end.
        page_end = ((r_word_counter & in_page_mask) == in_page_mask)
                   && ({1'b0, i_cfg.page_log2} <= IDX_BITS);
        emit        = page_end || i_item.last;
        differs     = i_item.word_a != i_item.word_b;
        idx_ext     = DATA_W'(r_word_counter);
        idx_shifted = idx_ext >> i_cfg.page_log2;

        n_cur_dirty   = r_cur_dirty;
        n_dirty_count = r_dirty_count;
        n_err         = r_err;
        n_err_addr    = r_err_addr;
        if (differs) begin
            if (!r_cur_dirty) begin
                n_cur_dirty   = 1'b1;
                n_dirty_count = r_dirty_count + 1'b1;
            end
            if (i_cfg.mode == MODE_CHECK && !i_item.page_marked && !r_err) begin
                n_err      = 1'b1;
                n_err_addr = i_cfg.base_address + (idx_ext << BYTE_SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_counter <= '0;
            r_cur_dirty    <= 1'b0;
            r_dirty_count  <= '0;
            r_err          <= 1'b0;
            r_err_addr     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                if (i_item.last) begin
                    r_word_counter <= '0;
                    r_cur_dirty    <= 1'b0;
                    r_dirty_count  <= '0;
                    r_err          <= 1'b0;
                    r_err_addr     <= '0;
                end else begin
                    r_word_counter <= r_word_counter + 1'b1;
                    r_cur_dirty    <= page_end ? 1'b0 : n_cur_dirty;
                    r_dirty_count  <= n_dirty_count;
                    r_err          <= n_err;
                    r_err_addr     <= n_err_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_page_index   <= idx_shifted[COUNT_W-1:0];
            r_out_dirty    <= n_cur_dirty;
            r_out_total    <= n_dirty_count;
            r_out_err      <= n_err;
            r_out_err_addr <= n_err_addr;
            r_out_end      <= i_item.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_page_index    = r_page_index;
    assign o_dirty_flag    = r_out_dirty;
    assign o_dirty_total   = r_out_total;
    assign o_error_found   = r_out_err;
    assign o_error_address = r_out_err_addr;
    assign o_end_of_region = r_out_end;

endmodule

// ===== rtl/dirty_page_bitmap_tracker.sv =====
// Dirty page bitmap tracker. Word pairs from two memory images arrive in
// address order, one transaction per word, and are grouped into pages of
// 2^page_words_log2 words. At the last word of each page, and at the word
// flagged last, one result transaction reports the page index, whether any
// word of that page differed, and the running dirty page count; in check
// mode it also reports the first differing word whose page bit was clear,
// with its byte address. The block takes one word every clock cycle while
// results are taken, and each result is registered: the word sits in the
// input register while the compare and update logic, which also updates
// the core state (word counter, dirty flag, counts), feeds the result
// register. While a result waits, the input register still takes one more
// word if it is empty; after that the input stalls until the result is
// taken. Configuration must be written only while no transaction is in
// flight; page sizes above 2^20 words are saturated at write time.
module dirty_page_bitmap_tracker
    import dpbt_pkg::*;
#(
    parameter int WORD_INDEX_BITS = DEF_WORD_INDEX_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]      i_cfg_data,

    // Word pair input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [DATA_W-1:0]      i_word_a,
    input  logic [DATA_W-1:0]      i_word_b,
    input  logic                   i_page_marked,
    input  logic                   i_last,

    // Page result channel.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_W-1:0]     o_page_index,
    output logic                   o_dirty_flag,
    output logic [COUNT_W-1:0]     o_dirty_total,
    output logic                   o_error_found,
    output logic [DATA_W-1:0]      o_error_address,
    output logic                   o_end_of_region
);

    t_cfg  r_cfg;
    logic  r_in_valid;
    t_item r_item;
    logic  take;

    // Configuration registers. Unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_GENERATE;
            r_cfg.page_log2    <= PAGE_LOG2_RESET;
            r_cfg.base_address <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE: begin
                    r_cfg.mode <= i_cfg_data[0];
                end
                CFG_PAGE_LOG2: begin
                    r_cfg.page_log2 <= (i_cfg_data[PAGE_LOG2_W-1:0] > MAX_PAGE_LOG2)
                                       ? MAX_PAGE_LOG2 : i_cfg_data[PAGE_LOG2_W-1:0];
                end
                CFG_BASE_ADDR: begin
                    r_cfg.base_address <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The input register accepts a new word whenever it is empty or its
    // current word moves into the core in the same cycle.
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.word_a      <= i_word_a;
            r_item.word_b      <= i_word_b;
            r_item.page_marked <= i_page_marked;
            r_item.last        <= i_last;
        end
    end

    dpbt_core #(
        .WORD_INDEX_BITS (WORD_INDEX_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_valid    (r_in_valid),
        .i_item          (r_item),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_page_index    (o_page_index),
        .o_dirty_flag    (o_dirty_flag),
        .o_dirty_total   (o_dirty_total),
        .o_error_found   (o_error_found),
        .o_error_address (o_error_address),
        .o_end_of_region (o_end_of_region)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

import dpbt_pkg::*;

// One page result as the block reports it.
typedef struct {
    logic [COUNT_W-1:0] page_index;
    logic               dirty_flag;
    logic [COUNT_W-1:0] dirty_total;
    logic               error_found;
    logic [DATA_W-1:0]  error_address;
    logic               end_of_region;
} t_page_report;

// Mirrors the page tracking of the block and holds the page reports that are
// still owed by it, oldest first.
class dirty_page_predictor #(int CNT_BITS = 16);
    logic                   mode;
    logic [PAGE_LOG2_W-1:0] page_log2;
    logic [DATA_W-1:0]      base_address;

    logic [CNT_BITS-1:0]    word_index;
    logic                   cur_dirty;
    logic [COUNT_W-1:0]     dirty_pages;
    logic                   error_seen;
    logic [DATA_W-1:0]      error_addr;

    t_page_report           pending_pages[$];
    int                     mismatch_count;
    int                     reports_checked;

    function new();
        mode            = MODE_GENERATE;
        page_log2       = PAGE_LOG2_RESET;
        base_address    = '0;
        mismatch_count  = 0;
        reports_checked = 0;
        clear_region();
    endfunction

    function void clear_region();
        word_index  = '0;
        cur_dirty   = 1'b0;
        dirty_pages = '0;
        error_seen  = 1'b0;
        error_addr  = '0;
    endfunction

    function void note_register(t_cfg_reg reg_index, logic [DATA_W-1:0] data);
        case (reg_index)
            CFG_MODE: begin
                mode = data[0];
            end
            CFG_PAGE_LOG2: begin
                page_log2 = (data[PAGE_LOG2_W-1:0] > MAX_PAGE_LOG2) ?
                            MAX_PAGE_LOG2 : data[PAGE_LOG2_W-1:0];
            end
            CFG_BASE_ADDR: begin
                base_address = data;
            end
            default: begin
            end
        endcase
    endfunction

    function void absorb_word(t_item w);
        logic [DATA_W-1:0] idx;
        logic [DATA_W-1:0] page_mask;
        logic              page_end;
        t_page_report      rep;
        idx       = DATA_W'(word_index);
        page_mask = (64'd1 << page_log2) - 64'd1;
        page_end  = (idx & page_mask) == page_mask;
        if (w.word_a != w.word_b) begin
            if (!cur_dirty) begin
                cur_dirty   = 1'b1;
                dirty_pages = dirty_pages + 1'b1;
            end
            if (mode == MODE_CHECK && !w.page_marked && !error_seen) begin
                error_seen = 1'b1;
                error_addr = base_address + (idx << BYTE_SHIFT);
            end
        end
        if (page_end || w.last) begin
            rep.page_index    = COUNT_W'(idx >> page_log2);
            rep.dirty_flag    = cur_dirty;
            rep.dirty_total   = dirty_pages;
            rep.error_found   = error_seen;
            rep.error_address = error_addr;
            rep.end_of_region = w.last;
            pending_pages.push_back(rep);
        end
        if (w.last) begin
            clear_region();
        end else begin
            if (page_end)
                cur_dirty = 1'b0;
            word_index = word_index + 1'b1;
        end
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function void compare_page(t_page_report got);
        t_page_report want;
        if (pending_pages.size() == 0) begin
            $display("%0t: page result with none pending, page_index 0x%0h",
                     $time, got.page_index);
            mismatch_count++;
            return;
        end
        want = pending_pages.pop_front();
        reports_checked++;
        check_field("page_index", DATA_W'(want.page_index), DATA_W'(got.page_index));
        check_field("dirty_flag", DATA_W'(want.dirty_flag), DATA_W'(got.dirty_flag));
        check_field("dirty_total", DATA_W'(want.dirty_total),
                    DATA_W'(got.dirty_total));
        check_field("error_found", DATA_W'(want.error_found),
                    DATA_W'(got.error_found));
        check_field("error_address", want.error_address, got.error_address);
        check_field("end_of_region", DATA_W'(want.end_of_region),
                    DATA_W'(got.end_of_region));
    endfunction
endclass

module testbench;

    // A 16-bit word counter makes the largest page sizes longer than the
    // counter, so that those pages report only at region end.
    localparam int CNT_BITS      = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // A word passes the input register before its result is registered; the
    // settle wait covers words that make no result and are still in the
    // input register once all results are in.
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 130;
    // After this many page results the receiver holds off for a long time.
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 250;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = CFG_MODE;
    logic [DATA_W-1:0]      cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [DATA_W-1:0]      word_a      = '0;
    logic [DATA_W-1:0]      word_b      = '0;
    logic                   page_marked = 1'b0;
    logic                   last        = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [COUNT_W-1:0]     page_index;
    logic                   dirty_flag;
    logic [COUNT_W-1:0]     dirty_total;
    logic                   error_found;
    logic [DATA_W-1:0]      error_address;
    logic                   end_of_region;

    int unsigned            cycle_count = 0;
    dirty_page_predictor #(CNT_BITS) tracker_model;

    dirty_page_bitmap_tracker #(
        .WORD_INDEX_BITS(CNT_BITS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_word_a       (word_a),
        .i_word_b       (word_b),
        .i_page_marked  (page_marked),
        .i_last         (last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_page_index   (page_index),
        .o_dirty_flag   (dirty_flag),
        .o_dirty_total  (dirty_total),
        .o_error_found  (error_found),
        .o_error_address(error_address),
        .o_end_of_region(end_of_region)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. A correct run ends far below this limit, so reaching it means
    // the block stopped accepting words or stopped delivering results.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. Every transaction accepted on the result channel is
    // compared with the oldest page report still owed. Outputs are sampled at
    // the rising edge, before the block's registers update.
    always @(posedge clk) begin
        t_page_report got;
        if (rst_n && out_valid && out_ready) begin
            got.page_index    = page_index;
            got.dirty_flag    = dirty_flag;
            got.dirty_total   = dirty_total;
            got.error_found   = error_found;
            got.error_address = error_address;
            got.end_of_region = end_of_region;
            tracker_model.compare_page(got);
        end
    end

    // Receiver stall pattern. It runs in stretches of random length, each
    // either always ready, mostly ready or mostly stalled, so stalls land on
    // every phase of the block's work. Once, after enough results have come
    // in, it holds off for a long time while the sender keeps offering words,
    // which fills the block and must stall its input channel.
    initial begin : receiver
        int  run_left;
        int  style;
        bit  hold_done;
        run_left  = 0;
        style     = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && tracker_model != null &&
                tracker_model.reports_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (run_left == 0) begin
                style    = $urandom_range(0, 2);
                run_left = $urandom_range(10, 80);
            end
            run_left--;
            case (style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offers one word pair and waits until the block takes the transaction.
    // Valid stays high after acceptance so that back-to-back calls stream
    // one word per cycle while the block stays ready.
    task automatic push_word(t_item w);
        @(negedge clk);
        in_valid    <= 1'b1;
        word_a      <= w.word_a;
        word_b      <= w.word_b;
        page_marked <= w.page_marked;
        last        <= w.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker_model.absorb_word(w);
    endtask

    // Leaves the input channel idle for the given number of cycles.
    task automatic sender_gap(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stops sending and waits until every owed page report has arrived and
    // the words that make no report have left the pipeline. Registers may be
    // written after this, also in the middle of a region.
    task automatic drain_pages();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker_model.pending_pages.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg reg_index, logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker_model.note_register(reg_index, data);
    endtask

    function automatic t_item word_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                        logic marked, logic is_last);
        t_item w;
        w.word_a      = a;
        w.word_b      = b;
        w.page_marked = marked;
        w.last        = is_last;
        return w;
    endfunction

    // Random word pair. diff_permille sets how often the two words differ;
    // a difference is a single flipped bit, a full inversion or unrelated data.
    function automatic t_item random_pair(int diff_permille, logic is_last);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       a = '0;
            1:       a = '1;
            default: ;
        endcase
        b = a;
        if ($urandom_range(0, 999) < diff_permille) begin
            case ($urandom_range(0, 2))
                0:       b = a ^ (64'd1 << $urandom_range(0, DATA_W - 1));
                1:       b = ~a;
                default: b = {$urandom, $urandom};
            endcase
        end
        return word_pair(a, b, 1'($urandom_range(0, 1)), is_last);
    endfunction

    initial begin : stimulus
        logic [DATA_W-1:0] data;
        int                region_left;
        int                burst_left;
        int                diff_permille;
        int                phase;
        int                n;

        tracker_model = new();
        region_left   = 0;
        burst_left    = 0;
        diff_permille = 0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: generate mode and 512-word pages,
        // so the three words below make one report, at the region end.
        push_word(word_pair('0, '0, 1'b0, 1'b0));
        push_word(word_pair('0, '1, 1'b0, 1'b0));
        push_word(word_pair('1, '1, 1'b1, 1'b1));
        drain_pages();

        // Check mode with one-word pages. The base sits just below the top of
        // the address space, so the first error address wraps to zero.
        write_reg(CFG_MODE, 64'd1);
        write_reg(CFG_PAGE_LOG2, 64'd0);
        write_reg(CFG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFF0);
        push_word(word_pair('0, '0, 1'b0, 1'b0));
        push_word(word_pair('1, '0, 1'b1, 1'b0));
        push_word(word_pair('0, 64'd1, 1'b0, 1'b0));
        push_word(word_pair(64'h8000_0000_0000_0000, '0, 1'b0, 1'b0));
        push_word(word_pair(64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0,
                            1'b0, 1'b1));
        // A new region starts with clean state; its first word errs at once.
        push_word(word_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                            1'b0, 1'b0));
        push_word(word_pair('1, '1, 1'b1, 1'b1));
        drain_pages();

        // An oversized page size saturates at the largest page. Upper data
        // bits of the mode register are ignored, so this selects generate.
        write_reg(CFG_PAGE_LOG2, 64'd31);
        write_reg(CFG_MODE, 64'h2);
        push_word(word_pair('0, '1, 1'b0, 1'b0));
        push_word(word_pair(64'd7, 64'd6, 1'b0, 1'b0));
        push_word(word_pair('1, '0, 1'b0, 1'b1));
        drain_pages();

        // Four-word pages. An error latched in check mode must survive a
        // switch to generate mode in the middle of the region.
        write_reg(CFG_MODE, '1);
        write_reg(CFG_PAGE_LOG2, 64'hFFFF_FFFF_FFFF_FFE2);
        write_reg(CFG_BASE_ADDR, 64'h8000_0000_0000_0000);
        push_word(word_pair(64'd3, 64'd3, 1'b0, 1'b0));
        push_word(word_pair(64'd3, 64'd2, 1'b0, 1'b0));
        push_word(word_pair(64'd9, 64'd9, 1'b0, 1'b0));
        drain_pages();
        write_reg(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        push_word(word_pair('0, 64'd4, 1'b0, 1'b0));
        push_word(word_pair('1, 64'd4, 1'b0, 1'b0));
        push_word(word_pair(64'd4, 64'd4, 1'b1, 1'b1));
        push_word(word_pair(64'd4, 64'd5, 1'b0, 1'b1));

        // Random phases. Each phase starts once every owed report is in,
        // often in the middle of a region, with new register values. Small
        // pages dominate so reports come often; large and oversized page
        // sizes appear now and then.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pages();
            write_reg(CFG_MODE, {$urandom, $urandom});
            data = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: data[PAGE_LOG2_W-1:0] = PAGE_LOG2_W'($urandom_range(0, 4));
                6, 7:             data[PAGE_LOG2_W-1:0] = PAGE_LOG2_W'($urandom_range(5, 9));
                8:                data[PAGE_LOG2_W-1:0] = MAX_PAGE_LOG2;
                default:          data[PAGE_LOG2_W-1:0] = PAGE_LOG2_W'($urandom_range(21, 31));
            endcase
            write_reg(CFG_PAGE_LOG2, data);
            case ($urandom_range(0, 3))
                0:       data = '0;
                1:       data = '1;
                default: data = {$urandom, $urandom};
            endcase
            write_reg(CFG_BASE_ADDR, data);

            for (n = 0; n < PHASE_WORDS; n++) begin
                if (region_left == 0) begin
                    region_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0:       diff_permille = 0;
                        1:       diff_permille = 30;
                        2:       diff_permille = 300;
                        default: diff_permille = 900;
                    endcase
                end
                if (burst_left == 0) begin
                    sender_gap($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 30);
                end
                push_word(random_pair(diff_permille, region_left == 1));
                region_left--;
                burst_left--;
            end
        end

        // Wait out every owed report, then a little longer so that a stray
        // extra report would still be caught.
        drain_pages();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (tracker_model.mismatch_count == 0 &&
            tracker_model.pending_pages.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
